// ===== design/spwlt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spwlt_pkg
// Shared sizes and the sequencer state type for the S+P line transform.
// ============================================================================
package spwlt_pkg;

    localparam int MAX_LEN  = 64;
    localparam int CAP_LEN  = (MAX_LEN / 2) * 2;
    localparam int HALF_MAX = CAP_LEN / 2;

    localparam int DATA_W   = 16;
    localparam int LL_W     = 7;
    localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PIDX_W   = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;
    localparam int EL_W     = (ADDR_W + 1 > LL_W) ? ADDR_W + 1 : LL_W;

    localparam logic [LL_W-1:0] LL_RESET = LL_W'(64);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SM_B,
        ST_SM_C,
        ST_DT_A,
        ST_DT_B,
        ST_DT_C
    } state_t;

endpackage

// ===== design/spwlt_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spwlt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module spwlt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sp_wavelet_line_transform.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sp_wavelet_line_transform
// One level of the S+P integer wavelet over a line of even length N.
// ============================================================================
// Output order: the smooth words of a line go out first, each registered after
// its ST_SM_B/ST_SM_C pair; the detail words follow after ST_DT_A.
// Throughput: one sample per cycle while loading; busy then stays high and no
// sample is taken while N words go out, one per pair of states; the receiver cannot stall.
// Reset: line_length returns to 64, the fill count to zero; RAM contents
// are not cleared (no entry is used before it is written in a line).
// ============================================================================
module sp_wavelet_line_transform (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spwlt_pkg::LL_W-1:0]    cfg_data,
    input  logic                          start,
    input  logic signed [15:0]            sample,
    output logic                          busy,
    output logic                          valid,
    output logic signed [15:0]            coeff,
    output logic                          last_of_line
);

    // ------------------------------------------------------------------
    // Configuration and effective line length
    // ------------------------------------------------------------------
    logic [spwlt_pkg::LL_W-1:0]   line_length_reg;
    logic [spwlt_pkg::EL_W-1:0]   len_even;
    logic [spwlt_pkg::EL_W-1:0]   eff_len;
    logic [spwlt_pkg::EL_W-1:0]   half_m1;

    // Odd lengths drop to even, then clamp to [2, CAP_LEN].
    always_comb
    begin
        len_even = spwlt_pkg::EL_W'({line_length_reg[spwlt_pkg::LL_W-1:1], 1'b0});
        if (len_even < spwlt_pkg::EL_W'(2))
        begin
            eff_len = spwlt_pkg::EL_W'(2);
        end
        else if (len_even > spwlt_pkg::EL_W'(spwlt_pkg::CAP_LEN))
        begin
            eff_len = spwlt_pkg::EL_W'(spwlt_pkg::CAP_LEN);
        end
        else
        begin
            eff_len = len_even;
        end
        half_m1 = (eff_len >> 1) - spwlt_pkg::EL_W'(1);
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    spwlt_pkg::state_t                 state_reg, state_next;
    logic [spwlt_pkg::ADDR_W-1:0]      load_count_reg;
    logic [spwlt_pkg::PIDX_W-1:0]      pidx_reg;      // pair index n
    logic signed [15:0]                a_reg;         // x[2n]
    logic signed [15:0]                sprev_reg;     // s[n-1]
    logic                              valid_reg;
    logic signed [15:0]                coeff_reg;
    logic                              last_reg;

    logic                              accept;
    logic                              line_full;
    logic                              last_pair;
    logic                              inner;
    logic [spwlt_pkg::PIDX_W-1:0]      pidx_inc;
    logic [spwlt_pkg::PIDX_W-1:0]      pidx_dec;

    assign accept    = start && (state_reg == spwlt_pkg::ST_LOAD);
    assign line_full = (spwlt_pkg::EL_W'(load_count_reg) + spwlt_pkg::EL_W'(1)) >= eff_len;
    assign last_pair = (spwlt_pkg::EL_W'(pidx_reg) == half_m1);
    assign inner     = (pidx_reg != '0) && !last_pair;
    assign pidx_inc  = pidx_reg + spwlt_pkg::PIDX_W'(1);
    assign pidx_dec  = pidx_reg - spwlt_pkg::PIDX_W'(1);

    // ------------------------------------------------------------------
    // Memories: line samples and smooth values of the current line
    // ------------------------------------------------------------------
    logic                              line_we;
    logic [spwlt_pkg::ADDR_W-1:0]      line_raddr;
    logic [15:0]                       line_rdata;
    logic                              sm_we;
    logic [spwlt_pkg::PIDX_W-1:0]      sm_raddr;
    logic [15:0]                       sm_rdata;
    logic [15:0]                       sm_wdata;

    spwlt_ram #(
        .WIDTH (spwlt_pkg::DATA_W),
        .DEPTH (spwlt_pkg::MAX_LEN),
        .AW    (spwlt_pkg::ADDR_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (load_count_reg),
        .wdata (sample),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    spwlt_ram #(
        .WIDTH (spwlt_pkg::DATA_W),
        .DEPTH (spwlt_pkg::HALF_MAX),
        .AW    (spwlt_pkg::PIDX_W)
    ) u_smooth_ram (
        .clk   (clk),
        .we    (sm_we),
        .waddr (pidx_reg),
        .wdata (sm_wdata),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    // ------------------------------------------------------------------
    // Arithmetic
    // smooth = (a + b) / 2 toward zero: add 1 to a negative sum, then shift.
    // detail = a - b (+ (s[n+1] - s[n-1]) >>> 2 on inner pairs), wrapped.
    // ------------------------------------------------------------------
    logic signed [16:0]                pair_sum;
    logic signed [16:0]                pair_sum_adj;
    logic signed [17:0]                pair_diff;
    logic signed [16:0]                s_delta;
    logic signed [16:0]                s_corr;
    logic signed [17:0]                detail;

    always_comb
    begin
        pair_sum     = 17'(a_reg) + 17'($signed(line_rdata));
        pair_sum_adj = pair_sum + 17'({16'b0, pair_sum[16]});
        sm_wdata     = pair_sum_adj[16:1];
        pair_diff    = 18'(a_reg) - 18'($signed(line_rdata));
        s_delta      = 17'($signed(sm_rdata)) - 17'(sprev_reg);
        s_corr       = s_delta >>> 2;
        detail       = inner ? (pair_diff + 18'(s_corr)) : pair_diff;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spwlt_pkg::ST_LOAD:
            begin
                if (accept && line_full)
                begin
                    state_next = spwlt_pkg::ST_SM_B;
                end
            end
            spwlt_pkg::ST_SM_B:
            begin
                state_next = spwlt_pkg::ST_SM_C;
            end
            spwlt_pkg::ST_SM_C:
            begin
                state_next = last_pair ? spwlt_pkg::ST_DT_A : spwlt_pkg::ST_SM_B;
            end
            spwlt_pkg::ST_DT_A:
            begin
                state_next = spwlt_pkg::ST_DT_B;
            end
            spwlt_pkg::ST_DT_B:
            begin
                state_next = spwlt_pkg::ST_DT_C;
            end
            spwlt_pkg::ST_DT_C:
            begin
                state_next = last_pair ? spwlt_pkg::ST_LOAD : spwlt_pkg::ST_DT_B;
            end
            default:
            begin
                state_next = spwlt_pkg::ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory controls per state. Reads are issued in the state before their use;
    // x[0] is read all through LOAD so it is ready when the line closes.
    // ------------------------------------------------------------------
    always_comb
    begin
        line_we    = 1'b0;
        sm_we      = 1'b0;
        line_raddr = '0;
        sm_raddr   = pidx_reg;
        unique case (state_reg)
            spwlt_pkg::ST_LOAD:
            begin
                line_we = accept;
            end
            spwlt_pkg::ST_SM_B:
            begin
                line_raddr = spwlt_pkg::ADDR_W'({pidx_reg, 1'b1});
            end
            spwlt_pkg::ST_SM_C:
            begin
                sm_we      = 1'b1;
                line_raddr = spwlt_pkg::ADDR_W'({pidx_inc, 1'b0});
            end
            spwlt_pkg::ST_DT_A:
            begin
                line_raddr = spwlt_pkg::ADDR_W'({pidx_reg, 1'b0});
                sm_raddr   = pidx_dec;
            end
            spwlt_pkg::ST_DT_B:
            begin
                line_raddr = spwlt_pkg::ADDR_W'({pidx_reg, 1'b1});
                sm_raddr   = pidx_inc;
            end
            spwlt_pkg::ST_DT_C:
            begin
                line_raddr = spwlt_pkg::ADDR_W'({pidx_inc, 1'b0});
                sm_raddr   = pidx_reg;    // s[(n+1)-1]
            end
            default:
            begin
                line_raddr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= spwlt_pkg::ST_LOAD;
            line_length_reg <= spwlt_pkg::LL_RESET;
            load_count_reg  <= '0;
            pidx_reg        <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == spwlt_pkg::ST_SM_C) ||
                         (state_reg == spwlt_pkg::ST_DT_C);

            // A length write drops any partial line.
            if (cfg_we)
            begin
                line_length_reg <= cfg_data;
                load_count_reg  <= '0;
            end
            else if (accept)
            begin
                load_count_reg <= line_full ? '0 : load_count_reg + spwlt_pkg::ADDR_W'(1);
            end

            case (state_reg)
                spwlt_pkg::ST_SM_C,
                spwlt_pkg::ST_DT_C:
                begin
                    pidx_reg <= last_pair ? '0 : pidx_inc;
                end
                spwlt_pkg::ST_LOAD:
                begin
                    pidx_reg <= '0;
                end
                default:
                begin
                    pidx_reg <= pidx_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            spwlt_pkg::ST_SM_B,
            spwlt_pkg::ST_DT_B:
            begin
                a_reg     <= $signed(line_rdata);
                sprev_reg <= $signed(sm_rdata);
            end
            spwlt_pkg::ST_SM_C:
            begin
                coeff_reg <= $signed(sm_wdata);
                last_reg  <= 1'b0;
            end
            spwlt_pkg::ST_DT_C:
            begin
                coeff_reg <= detail[15:0];
                last_reg  <= last_pair;
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

    assign busy         = (state_reg != spwlt_pkg::ST_LOAD);
    assign valid        = valid_reg;
    assign coeff        = coeff_reg;
    assign last_of_line = last_reg;

endmodule
